// File: src/mps_pkg.sv
// ============================================================================
// mps_pkg
// Shared types and constants of the moisture probe sequencer: register
// indexes, timer select codes, percent limits and the command/status bundles
// that join the controller and the datapath.
// ============================================================================
package mps_pkg;

    // field widths
    localparam int unsigned TIME_W = 32;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned RAW_W  = 8;
    localparam int unsigned IDX_W  = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WARMUP_TIME  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROBE_GAP    = 3'd1;
    localparam logic [IDX_W-1:0] REG_IDLE_TIME    = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_STEP     = 3'd3;
    localparam logic [IDX_W-1:0] REG_ADOPT_WINDOW = 3'd4;

    // configuration reset values
    localparam logic [TIME_W-1:0] WARMUP_TIME_RST  = 32'd1000;
    localparam logic [TIME_W-1:0] PROBE_GAP_RST    = 32'd50;
    localparam logic [TIME_W-1:0] IDLE_TIME_RST    = 32'd60000;
    localparam logic [PCT_W-1:0]  MIN_STEP_RST     = 7'd3;
    localparam logic [TIME_W-1:0] ADOPT_WINDOW_RST = 32'd3600000;

    // reading clamp: anything above full scale reads as the clamp value
    localparam logic [RAW_W-1:0] PCT_FULL  = 8'd100;
    localparam logic [PCT_W-1:0] PCT_CLAMP = 7'd99;

    // which interval the phase timer is tested against
    localparam logic [1:0] SPAN_WARMUP = 2'd0;
    localparam logic [1:0] SPAN_GAP    = 2'd1;
    localparam logic [1:0] SPAN_IDLE   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       capture;      // latch the accepted poll
        logic [1:0] span_sel;     // interval for the elapsed test
        logic       set_start;    // phase start time takes the poll time
        logic       clear_count;  // restart probe counting
        logic       take_probe;   // shift the reading into the probe store
        logic       power_on;
        logic       power_off;
        logic       clr_flags;    // clear changed / increased
        logic       med_start;    // reset the median scan
        logic       med_step;     // test one candidate, rotate the store
        logic       apply_med;    // compare median with current level
        logic       load_out;     // fill the result register
    } mps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic elapsed;     // phase timer beyond selected interval
        logic count_zero;  // no probe taken yet in this measurement
        logic probe_last;  // the next probe completes the measurement
        logic med_last;    // last candidate of the median scan
    } mps_status_t;

endpackage

// File: src/mps_ctrl.sv
// ============================================================================
// mps_ctrl
// Controller: the measurement phase machine and the per-poll sequencer that
// drives the datapath, plus the result valid flag of the output channel.
// ============================================================================
module mps_ctrl
    import mps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  mps_status_t status,
    output mps_cmd_t    cmd
);

    // measurement phases
    localparam logic [2:0] PH_START_WARMUP  = 3'd0;
    localparam logic [2:0] PH_WARMUP        = 3'd1;
    localparam logic [2:0] PH_START_MEASURE = 3'd2;
    localparam logic [2:0] PH_MEASURE       = 3'd3;
    localparam logic [2:0] PH_START_IDLE    = 3'd4;
    localparam logic [2:0] PH_IDLE          = 3'd5;

    // per-poll sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_MEDIAN = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // sequencing and phase decisions
    always_comb begin
        phase_next   = phase_reg;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.span_sel = SPAN_GAP;

        // result beat leaves on its handshake
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.clr_flags = 1'b1;
                state_next    = S_EMIT;
                case (phase_reg)
                    PH_WARMUP: begin
                        cmd.span_sel = SPAN_WARMUP;
                        if (status.elapsed) begin
                            phase_next = PH_START_MEASURE;
                        end
                    end
                    PH_START_MEASURE: begin
                        cmd.clear_count = 1'b1;
                        phase_next      = PH_MEASURE;
                    end
                    PH_MEASURE: begin
                        cmd.span_sel = SPAN_GAP;
                        if (status.count_zero || status.elapsed) begin
                            cmd.set_start  = 1'b1;
                            cmd.take_probe = 1'b1;
                            if (status.probe_last) begin
                                cmd.power_off = 1'b1;
                                cmd.med_start = 1'b1;
                                phase_next    = PH_START_IDLE;
                                state_next    = S_MEDIAN;
                            end
                        end
                    end
                    PH_START_IDLE: begin
                        cmd.set_start = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    PH_IDLE: begin
                        cmd.span_sel = SPAN_IDLE;
                        if (status.elapsed) begin
                            phase_next = PH_START_WARMUP;
                        end
                    end
                    default: begin
                        // start warmup, and any code that cannot arise
                        cmd.set_start = 1'b1;
                        cmd.power_on  = 1'b1;
                        phase_next    = PH_WARMUP;
                    end
                endcase
            end
            S_MEDIAN: begin
                cmd.med_step = 1'b1;
                if (status.med_last) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.apply_med = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START_WARMUP;
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: src/mps_datapath.sv
// ============================================================================
// mps_datapath
// Datapath: configuration registers, phase and rise timers, the probe store
// with its rotating median scan, level tracking and the result register.
// ============================================================================
module mps_datapath
    import mps_pkg::*;
#(
    parameter int unsigned PROBE_COUNT = 5
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  mps_cmd_t            cmd,
    output mps_status_t         status,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [TIME_W-1:0]   cfg_wdata,
    input  logic [TIME_W-1:0]   s_now_ms,
    input  logic [RAW_W-1:0]    s_sample_percent,
    output logic                m_sensor_power_on,
    output logic                m_changed,
    output logic                m_increased,
    output logic [PCT_W-1:0]    m_moisture_now,
    output logic [PCT_W-1:0]    m_moisture_peak
);

    localparam int unsigned CW      = $clog2(PROBE_COUNT + 1);
    localparam int unsigned MED_IDX = PROBE_COUNT / 2;

    // configuration
    logic [TIME_W-1:0] warmup_reg, warmup_next;
    logic [TIME_W-1:0] gap_reg, gap_next;
    logic [TIME_W-1:0] idle_reg, idle_next;
    logic [PCT_W-1:0]  step_reg, step_next;
    logic [TIME_W-1:0] adopt_reg, adopt_next;

    // poll and measurement state
    logic [TIME_W-1:0] now_reg, now_next;
    logic [PCT_W-1:0]  sample_reg, sample_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] rise_reg, rise_next;
    logic [PCT_W-1:0]  store_reg [PROBE_COUNT];
    logic [PCT_W-1:0]  store_next [PROBE_COUNT];
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     med_cnt_reg, med_cnt_next;
    logic [PCT_W-1:0]  med_reg, med_next;
    logic [PCT_W-1:0]  level_reg, level_next;
    logic [PCT_W-1:0]  peak_reg, peak_next;
    logic              power_reg, power_next;
    logic              changed_reg, changed_next;
    logic              incr_reg, incr_next;

    // result register
    logic              o_power_reg, o_power_next;
    logic              o_changed_reg, o_changed_next;
    logic              o_incr_reg, o_incr_next;
    logic [PCT_W-1:0]  o_now_reg, o_now_next;
    logic [PCT_W-1:0]  o_peak_reg, o_peak_next;

    // timer and median helpers
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_rise;
    logic [CW-1:0]     less_cnt;
    logic [CW-1:0]     le_cnt;
    logic [PCT_W-1:0]  cand;
    logic [PCT_W-1:0]  diff;
    logic [PCT_W:0]    rise_limit;

    // elapsed test against the selected interval
    always_comb begin
        case (cmd.span_sel)
            SPAN_WARMUP: span = warmup_reg;
            SPAN_GAP:    span = gap_reg;
            SPAN_IDLE:   span = idle_reg;
            default:     span = idle_reg;
        endcase
    end

    assign since_start       = now_reg - start_reg;
    assign status.elapsed    = (since_start > span);
    assign status.count_zero = (count_reg == '0);
    assign status.probe_last = (count_reg == CW'(PROBE_COUNT - 1));
    assign status.med_last   = (med_cnt_reg == CW'(PROBE_COUNT - 1));

    // rank of the head candidate against the whole store
    assign cand = store_reg[0];
    always_comb begin
        less_cnt = '0;
        le_cnt   = '0;
        for (int j = 0; j < PROBE_COUNT; j++) begin
            less_cnt = less_cnt + CW'(store_reg[j] < cand);
            le_cnt   = le_cnt + CW'(store_reg[j] <= cand);
        end
    end

    // median against current level
    assign diff       = (med_reg > level_reg) ? (med_reg - level_reg) : (level_reg - med_reg);
    assign rise_limit = {1'b0, level_reg} + {1'b0, step_reg};
    assign since_rise = now_reg - rise_reg;

    // next-state logic
    always_comb begin
        warmup_next    = warmup_reg;
        gap_next       = gap_reg;
        idle_next      = idle_reg;
        step_next      = step_reg;
        adopt_next     = adopt_reg;
        now_next       = now_reg;
        sample_next    = sample_reg;
        start_next     = start_reg;
        rise_next      = rise_reg;
        store_next     = store_reg;
        count_next     = count_reg;
        med_cnt_next   = med_cnt_reg;
        med_next       = med_reg;
        level_next     = level_reg;
        peak_next      = peak_reg;
        power_next     = power_reg;
        changed_next   = changed_reg;
        incr_next      = incr_reg;
        o_power_next   = o_power_reg;
        o_changed_next = o_changed_reg;
        o_incr_next    = o_incr_reg;
        o_now_next     = o_now_reg;
        o_peak_next    = o_peak_reg;

        // configuration writes
        if (cfg_we) begin
            case (cfg_index)
                REG_WARMUP_TIME:  warmup_next = cfg_wdata;
                REG_PROBE_GAP:    gap_next    = cfg_wdata;
                REG_IDLE_TIME:    idle_next   = cfg_wdata;
                REG_MIN_STEP:     step_next   = cfg_wdata[PCT_W-1:0];
                REG_ADOPT_WINDOW: adopt_next  = cfg_wdata;
                default: ;
            endcase
        end

        // accepted poll, reading clamped
        if (cmd.capture) begin
            now_next    = s_now_ms;
            sample_next = (s_sample_percent > PCT_FULL) ? PCT_CLAMP
                                                        : s_sample_percent[PCT_W-1:0];
        end

        if (cmd.set_start) begin
            start_next = now_reg;
        end
        if (cmd.clear_count) begin
            count_next = '0;
        end
        if (cmd.power_on) begin
            power_next = 1'b1;
        end
        if (cmd.power_off) begin
            power_next = 1'b0;
        end
        if (cmd.clr_flags) begin
            changed_next = 1'b0;
            incr_next    = 1'b0;
        end

        // probe store: shift in a new probe, or rotate during the scan
        if (cmd.take_probe || cmd.med_step) begin
            for (int j = 0; j < PROBE_COUNT - 1; j++) begin
                store_next[j] = store_reg[j+1];
            end
            store_next[PROBE_COUNT-1] = cmd.take_probe ? sample_reg : store_reg[0];
        end
        if (cmd.take_probe) begin
            count_next = count_reg + 1'b1;
        end

        // median scan, one candidate a cycle
        if (cmd.med_start) begin
            med_cnt_next = '0;
        end
        if (cmd.med_step) begin
            med_cnt_next = med_cnt_reg + 1'b1;
            if (less_cnt <= CW'(MED_IDX) && CW'(MED_IDX) < le_cnt) begin
                med_next = cand;
            end
        end

        // level and peak tracking
        if (cmd.apply_med && diff >= step_reg) begin
            changed_next = 1'b1;
            level_next   = med_reg;
            if ({1'b0, med_reg} > rise_limit) begin
                incr_next = 1'b1;
                peak_next = med_reg;
                rise_next = now_reg;
            end else if (since_rise < adopt_reg) begin
                peak_next = med_reg;
            end else if (med_reg > peak_reg) begin
                peak_next = med_reg;
            end
        end

        // result beat
        if (cmd.load_out) begin
            o_power_next   = power_reg;
            o_changed_next = changed_reg;
            o_incr_next    = incr_reg;
            o_now_next     = level_reg;
            o_peak_next    = peak_reg;
        end
    end

    // state with reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_reg  <= WARMUP_TIME_RST;
            gap_reg     <= PROBE_GAP_RST;
            idle_reg    <= IDLE_TIME_RST;
            step_reg    <= MIN_STEP_RST;
            adopt_reg   <= ADOPT_WINDOW_RST;
            start_reg   <= '0;
            rise_reg    <= '0;
            count_reg   <= '0;
            level_reg   <= '0;
            peak_reg    <= '0;
            power_reg   <= 1'b1;
            changed_reg <= 1'b0;
            incr_reg    <= 1'b0;
            med_cnt_reg <= '0;
        end else begin
            warmup_reg  <= warmup_next;
            gap_reg     <= gap_next;
            idle_reg    <= idle_next;
            step_reg    <= step_next;
            adopt_reg   <= adopt_next;
            start_reg   <= start_next;
            rise_reg    <= rise_next;
            count_reg   <= count_next;
            level_reg   <= level_next;
            peak_reg    <= peak_next;
            power_reg   <= power_next;
            changed_reg <= changed_next;
            incr_reg    <= incr_next;
            med_cnt_reg <= med_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        now_reg       <= now_next;
        sample_reg    <= sample_next;
        store_reg     <= store_next;
        med_reg       <= med_next;
        o_power_reg   <= o_power_next;
        o_changed_reg <= o_changed_next;
        o_incr_reg    <= o_incr_next;
        o_now_reg     <= o_now_next;
        o_peak_reg    <= o_peak_next;
    end

    assign m_sensor_power_on = o_power_reg;
    assign m_changed         = o_changed_reg;
    assign m_increased       = o_incr_reg;
    assign m_moisture_now    = o_now_reg;
    assign m_moisture_peak   = o_peak_reg;

endmodule

// File: src/moisture_probe_sequencer.sv
// ============================================================================
// moisture_probe_sequencer
// Moisture probe sequencer: one result beat per poll beat. Each poll carries
// the millisecond time and a moisture reading; the block steps the sensor
// through warmup, probing and idle, and reports power, change and levels.
// Usage:
//   s_* channel: poll beats (s_now_ms, s_sample_percent), valid/ready.
//   m_* channel: result beats, one per poll, in poll order, valid/ready.
//   cfg_*: register write, taken when cfg_we is high; write only while idle, the block does not enforce it.
// Timing: a poll passes the EVAL and EMIT states before its result beat is
//   presented; the poll that completes a measurement passes EVAL, the
//   median scan that ranks one stored probe per cycle, UPDATE and EMIT.
//   The block takes no new poll until the previous one has left EMIT and
//   the sequencer is back in its idle state.
//   A new poll is accepted once the previous result sits in the output
//   register, so a poll may be taken while that result still waits.
// Reset: synchronous, active low; configuration returns to its defaults,
//   phase to start warmup with the sensor powered and both levels at zero.
// Stall: if m_ready stays low the finished result holds; the following poll
//   is evaluated and waits to enter the output register, and s_ready stays
//   low until it does.
// ============================================================================
module moisture_probe_sequencer
    import mps_pkg::*;
#(
    parameter int unsigned PROBE_COUNT = 5
)
(
    input  logic                aclk,
    input  logic                aresetn,
    // poll channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TIME_W-1:0]   s_now_ms,
    input  logic [RAW_W-1:0]    s_sample_percent,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_sensor_power_on,
    output logic                m_changed,
    output logic                m_increased,
    output logic [PCT_W-1:0]    m_moisture_now,
    output logic [PCT_W-1:0]    m_moisture_peak,
    // configuration
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [TIME_W-1:0]   cfg_wdata
);

    mps_cmd_t    cmd;
    mps_status_t status;

    // phase machine and sequencer
    mps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // timers, probe store, median and levels
    mps_datapath #(
        .PROBE_COUNT (PROBE_COUNT)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_now_ms          (s_now_ms),
        .s_sample_percent  (s_sample_percent),
        .m_sensor_power_on (m_sensor_power_on),
        .m_changed         (m_changed),
        .m_increased       (m_increased),
        .m_moisture_now    (m_moisture_now),
        .m_moisture_peak   (m_moisture_peak)
    );

endmodule
